@@ rtl/smsd_pkg.sv @@
package smsd_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int LEN_WIDTH       = 7;
  localparam int COUNT_WIDTH     = 32;

  // Sequencer states of the window update.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MED_LO,
    ST_MED_HI,
    ST_OLD_RD,
    ST_OLD_WAIT,
    ST_REM_SCAN,
    ST_REM_SHIFT,
    ST_INS_SHIFT,
    ST_INS_PLACE,
    ST_OUT
  } seq_state_t;

endpackage

@@ rtl/smsd_if.sv @@
interface smsd_in_if #(
  parameter int VALUE_WIDTH = 16
) (
  input logic clk
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface smsd_out_if #(
  parameter int VALUE_WIDTH = 16
) (
  input logic clk
);
  logic                 valid;
  logic                 ready;
  logic                 window_full;
  logic                 alert;
  logic [VALUE_WIDTH:0] twice_median;
  logic [31:0]          alert_count;

  modport source (output valid, output window_full, output alert, output twice_median,
                  output alert_count, input ready);
  modport sink (input valid, input window_full, input alert, input twice_median,
                input alert_count, output ready);
endinterface

@@ rtl/sliding_median_spike_detector.sv @@
// Channel   Dir  Fields
// in_ch     in   sample_value
// out_ch    out  window_full, alert, twice_median, alert_count
// cfg       in   cfg_we, cfg_wdata (window_len)
//
// With a full window an item walks the sorted window memory, which has one read and one
// write port, once to remove the oldest sample and once to insert the new one. While the
// window fills, only the insertion walk is made. One item is in work at a time.
// Reset is synchronous and clears only the control state; the memories are not cleared.
// The result waits in its own output register, so the next item is accepted meanwhile; the
// sequencer stalls in its last state only while the previous result has not been taken.
module sliding_median_spike_detector #(
  parameter int WINDOW_MAX  = smsd_pkg::WINDOW_MAX_DEF,
  parameter int VALUE_WIDTH = smsd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [smsd_pkg::LEN_WIDTH-1:0] cfg_wdata,
  smsd_in_if.sink                        in_ch,
  smsd_out_if.source                     out_ch
);
  import smsd_pkg::*;

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int FW = $clog2(WINDOW_MAX + 1);

  seq_state_t state, state_next;

  logic [FW-1:0]          window_len;
  logic [FW-1:0]          fill_level;
  logic [AW-1:0]          ring_pointer;
  logic [COUNT_WIDTH-1:0] alert_total;
  logic [VALUE_WIDTH-1:0] sample;
  logic [VALUE_WIDTH-1:0] old_value;
  logic [VALUE_WIDTH-1:0] lo_value;
  logic [FW-1:0]          idx;
  logic                   full;
  logic                   out_valid;
  logic                   out_alert;
  logic [VALUE_WIDTH:0]   out_twice;
  logic                   res_full;
  logic                   res_alert;
  logic [VALUE_WIDTH:0]   res_twice;
  logic [COUNT_WIDTH-1:0] res_count;

  // Memory ports.
  logic                   ring_we;
  logic [AW-1:0]          ring_rd_addr;
  logic [VALUE_WIDTH-1:0] ring_rd_data;
  logic                   sort_we;
  logic [AW-1:0]          sort_wr_addr;
  logic [VALUE_WIDTH-1:0] sort_wr_data;
  logic [AW-1:0]          sort_rd_addr;
  logic [VALUE_WIDTH-1:0] sort_rd_data;

  smsd_ram #(.DEPTH(WINDOW_MAX), .WIDTH(VALUE_WIDTH)) u_ring (
    .clk(clk), .wr_en(ring_we), .wr_addr(ring_pointer), .wr_data(sample),
    .rd_addr(ring_rd_addr), .rd_data(ring_rd_data)
  );

  smsd_ram #(.DEPTH(WINDOW_MAX), .WIDTH(VALUE_WIDTH)) u_sorted (
    .clk(clk), .wr_en(sort_we), .wr_addr(sort_wr_addr), .wr_data(sort_wr_data),
    .rd_addr(sort_rd_addr), .rd_data(sort_rd_data)
  );

  logic [FW-1:0] half;
  logic [FW-1:0] fill_m1;
  logic [VALUE_WIDTH:0] twice_val;
  logic [FW-1:0] cfg_len;

  assign half    = window_len >> 1;
  assign fill_m1 = fill_level - FW'(1);
  assign ring_rd_addr = ring_pointer;

  // Clamp a written length into one to the window maximum.
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_len = FW'(1);
    end else if (32'(cfg_wdata) > WINDOW_MAX) begin
      cfg_len = FW'(WINDOW_MAX);
    end else begin
      cfg_len = FW'(cfg_wdata);
    end
  end

  // Twice the median: the read data doubled for an odd length, else the registered lower value plus the read data.
  always_comb begin
    if (window_len[0]) begin
      twice_val = {sort_rd_data, 1'b0};
    end else begin
      twice_val = {1'b0, lo_value} + {1'b0, sort_rd_data};
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_next = (fill_level >= window_len) ? ST_MED_LO : ST_INS_SHIFT;
        end
      end
      ST_MED_LO:    state_next = ST_MED_HI;
      ST_MED_HI:    state_next = ST_OLD_RD;
      ST_OLD_RD:    state_next = ST_OLD_WAIT;
      ST_OLD_WAIT:  state_next = ST_REM_SCAN;
      ST_REM_SCAN: begin
        if (idx >= fill_level) begin
          state_next = ST_INS_SHIFT;
        end else if (sort_rd_data == old_value) begin
          state_next = ST_REM_SHIFT;
        end
      end
      ST_REM_SHIFT: begin
        if (idx >= fill_level) begin
          state_next = ST_INS_SHIFT;
        end
      end
      ST_INS_SHIFT: begin
        if (idx == '0 || sort_rd_data <= sample) begin
          state_next = ST_INS_PLACE;
        end
      end
      ST_INS_PLACE: state_next = ST_OUT;
      ST_OUT:       state_next = (out_valid && !out_ch.ready) ? ST_OUT : ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Memory addresses and writes for each state.
  always_comb begin
    sort_we      = 1'b0;
    sort_wr_addr = idx[AW-1:0];
    sort_wr_data = sort_rd_data;
    sort_rd_addr = idx[AW-1:0];
    ring_we      = 1'b0;
    case (state)
      ST_IDLE: begin
        // Prime the first read: median or last sorted entry.
        if (fill_level >= window_len) begin
          sort_rd_addr = window_len[0] ? half[AW-1:0] : AW'(half - FW'(1));
        end else begin
          sort_rd_addr = AW'(fill_m1);
        end
      end
      ST_MED_LO:   sort_rd_addr = half[AW-1:0];
      ST_MED_HI:   sort_rd_addr = '0;
      ST_OLD_RD:   sort_rd_addr = '0;
      ST_OLD_WAIT: sort_rd_addr = '0;
      ST_REM_SCAN: sort_rd_addr = AW'(idx + FW'(1));
      ST_REM_SHIFT: begin
        // Entry idx holds the read of idx; write it one place down.
        if (idx < fill_level) begin
          sort_rd_addr = AW'(idx + FW'(1));
          sort_we      = 1'b1;
          sort_wr_addr = AW'(idx - FW'(1));
        end else begin
          // Prime the insertion walk with the entry below the new last one.
          sort_rd_addr = AW'(fill_level - FW'(2));
        end
      end
      ST_INS_SHIFT: begin
        sort_rd_addr = AW'(idx - FW'(2));
        if (idx != '0 && sort_rd_data > sample) begin
          sort_we      = 1'b1;
          sort_wr_addr = idx[AW-1:0];
        end
      end
      ST_INS_PLACE: begin
        sort_we      = 1'b1;
        sort_wr_addr = idx[AW-1:0];
        sort_wr_data = sample;
        ring_we      = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_len   <= FW'(1);
      fill_level   <= '0;
      ring_pointer <= '0;
      alert_total  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      // The result register is loaded when it is free and emptied when taken.
      if (state == ST_OUT && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
        res_full  <= full;
        res_alert <= out_alert;
        res_twice <= out_twice;
        res_count <= alert_total;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        window_len   <= cfg_len;
        fill_level   <= '0;
        ring_pointer <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            sample    <= in_ch.sample_value;
            full      <= fill_level >= window_len;
            out_alert <= 1'b0;
            out_twice <= '0;
            idx       <= fill_level;
            if (32'(ring_pointer) >= 32'(window_len)) begin
              ring_pointer <= '0;
            end
          end
        end
        ST_MED_LO: lo_value <= sort_rd_data;
        ST_MED_HI: begin
          out_twice <= twice_val;
          if ({1'b0, twice_val} <= {2'b0, sample}) begin
            out_alert <= 1'b1;
            if (alert_total != '1) begin
              alert_total <= alert_total + COUNT_WIDTH'(1);
            end
          end
        end
        ST_OLD_WAIT: begin
          old_value <= ring_rd_data;
          idx       <= '0;
        end
        ST_REM_SCAN: begin
          if (idx >= fill_level) begin
            idx <= fill_level;
          end else if (sort_rd_data == old_value) begin
            idx <= idx + FW'(1);
          end else begin
            idx <= idx + FW'(1);
          end
        end
        ST_REM_SHIFT: begin
          if (idx >= fill_level) begin
            fill_level <= fill_m1;
            idx        <= fill_m1;
          end else begin
            idx <= idx + FW'(1);
          end
        end
        ST_INS_SHIFT: begin
          if (!(idx == '0 || sort_rd_data <= sample)) begin
            idx <= idx - FW'(1);
          end
        end
        ST_INS_PLACE: begin
          fill_level <= fill_level + FW'(1);
          if (32'(ring_pointer) + 1 >= 32'(window_len)) begin
            ring_pointer <= '0;
          end else begin
            ring_pointer <= ring_pointer + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Handshake and result outputs.
  assign in_ch.ready         = (state == ST_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.window_full  = res_full;
  assign out_ch.alert        = res_alert;
  assign out_ch.twice_median = res_twice;
  assign out_ch.alert_count  = res_count;

endmodule

@@ rtl/smsd_ram.sv @@
module smsd_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ tb/sliding_median_spike_detector_tb_pkg.sv @@
`timescale 1ns / 100ps

package smsd_tb_pkg;

  import smsd_pkg::*;

  // Fields of one expected or observed result.
  typedef struct packed {
    logic        window_full;
    logic        alert;
    logic [16:0] twice_median;
    logic [31:0] alert_count;
  } verdict_t;

endpackage

@@ tb/sliding_median_spike_detector_test.sv @@
`timescale 1ns / 100ps

module sliding_median_spike_detector_test;

  import smsd_pkg::*;
  import smsd_tb_pkg::*;

  localparam int WMAX = WINDOW_MAX_DEF;
  localparam int CYCLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [LEN_WIDTH-1:0] cfg_wdata = '0;

  smsd_in_if #(.VALUE_WIDTH(VALUE_WIDTH_DEF)) in_ch (.clk(clk));
  smsd_out_if #(.VALUE_WIDTH(VALUE_WIDTH_DEF)) out_ch (.clk(clk));

  sliding_median_spike_detector dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Own copy of the window state.
  logic [15:0] arrivals [WMAX];
  logic [15:0] ordered [$];
  int unsigned slot_ptr;
  int unsigned win_len;
  logic [31:0] spike_total;

  verdict_t pending_verdicts [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies a register write to the predicted state.
  function automatic void predict_length(logic [LEN_WIDTH-1:0] v);
    int unsigned n;
    n = v;
    if (n == 0) n = 1;
    if (n > WMAX) n = WMAX;
    win_len = n;
    ordered.delete();
    slot_ptr = 0;
  endfunction

  // Works out the result caused by one sample and slides the window.
  function automatic verdict_t predict_spike(logic [15:0] s);
    verdict_t r;
    int unsigned half;
    int pos;
    logic [16:0] tw;
    r = '0;
    if (ordered.size() >= win_len) begin
      half = win_len / 2;
      if (win_len % 2) tw = {ordered[half], 1'b0};
      else tw = ordered[half - 1] + ordered[half];
      r.window_full = 1'b1;
      r.twice_median = tw;
      if (tw <= {1'b0, s}) begin
        r.alert = 1'b1;
        if (spike_total != 32'hFFFF_FFFF) spike_total++;
      end
      if (slot_ptr >= win_len) slot_ptr = 0;
      for (pos = 0; pos < ordered.size(); pos++) begin
        if (ordered[pos] == arrivals[slot_ptr]) begin
          ordered.delete(pos);
          break;
        end
      end
    end
    if (slot_ptr >= win_len) slot_ptr = 0;
    arrivals[slot_ptr] = s;
    pos = ordered.size();
    while (pos > 0 && ordered[pos - 1] > s) pos--;
    ordered.insert(pos, s);
    slot_ptr++;
    if (slot_ptr >= win_len) slot_ptr = 0;
    r.alert_count = spike_total;
    return r;
  endfunction

  // Offers one sample and waits for its transaction; valid stays high afterwards.
  task automatic send_sample(logic [15:0] s);
    if (sender_idles && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (sender_idles && $urandom_range(99) < 7) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_value <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_verdicts.push_back(predict_spike(s));
  endtask

  // Waits until every result is in, then writes the window length.
  task automatic write_length(logic [LEN_WIDTH-1:0] v);
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    predict_length(v);
  endtask

  // Receiver side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(receiver_idles && $urandom_range(99) < 7);
    end
  end

  // Checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.window_full, out_ch.alert, out_ch.twice_median, out_ch.alert_count};
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        want = pending_verdicts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: full %b/%b alert %b/%b twice %0d/%0d count %0d/%0d",
                     want.window_full, got.window_full, want.alert, got.alert,
                     want.twice_median, got.twice_median,
                     want.alert_count, got.alert_count);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= CYCLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("TEST FAILED");
      $finish;
    end
  end

  // Extremes of the sample and the edges of the median comparison.
  task automatic test_directed_extremes();
    write_length(7'd0);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h8000);
    write_length(7'd2);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    write_length(7'd3);
    send_sample(16'd10);
    send_sample(16'd10);
    send_sample(16'd20);
    send_sample(16'd20);
    send_sample(16'd19);
    send_sample(16'd10);
  endtask

  // Oversized length and a window refilled after a length change.
  task automatic test_length_limits();
    int k;
    write_length(7'd127);
    for (k = 0; k < 70; k++) send_sample(16'($urandom));
    write_length(7'd65);
    for (k = 0; k < 66; k++) send_sample(16'($urandom_range(3)));
    write_length(7'd64);
    for (k = 0; k < 66; k++) send_sample(16'hFFFF);
  endtask

  // Random samples over a range of window lengths, mostly small ones.
  task automatic test_random_windows();
    int phase;
    int k;
    int n;
    for (phase = 0; phase < 16; phase++) begin
      if (phase % 5 == 4) write_length(7'($urandom_range(127)));
      else write_length(7'($urandom_range(1, 9)));
      n = (phase % 5 == 4) ? 70 : 40;
      sender_idles = (phase != 6);
      receiver_idles = (phase != 6);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(3))
          0: send_sample(16'($urandom));
          1: send_sample(16'($urandom_range(40)));
          2: send_sample(16'hFFF0 | 16'($urandom_range(15)));
          default: send_sample(16'($urandom_range(200)));
        endcase
      end
    end
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // The receiver holds off while samples keep coming.
  task automatic test_output_stall();
    int k;
    write_length(7'd4);
    hold_req = !hold_req;
    for (k = 0; k < 20; k++) send_sample(16'($urandom_range(100)));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_value = '0;
    spike_total = '0;
    win_len = 1;
    slot_ptr = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_length_limits();
    test_output_stall();
    test_random_windows();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/smsd_pkg.sv
rtl/smsd_if.sv
rtl/smsd_ram.sv
rtl/sliding_median_spike_detector.sv
tb/sliding_median_spike_detector_tb_pkg.sv
tb/sliding_median_spike_detector_test.sv
